// File: sv/ppp_pkg.sv
// Shared types and constants for the pinhole point projector.
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;
    typedef enum logic [2:0] {
        REG_U_X = 3'd0,
        REG_U_Y = 3'd1,
        REG_U_Z = 3'd2,
        REG_V_X = 3'd3,
        REG_V_Y = 3'd4,
        REG_V_Z = 3'd5,
        REG_WIDTH = 3'd6,
        REG_HEIGHT = 3'd7
    } t_reg_index;
    localparam int REG_INDEX_BITS = 3;
    localparam int COLOR_BITS = 8;
endpackage
`default_nettype wire

// File: sv/ppp_divider.sv
// Pipelined restoring divider: one quotient bit per stage, range check at the entry stage.
`timescale 1ns / 1ps
`default_nettype none
module ppp_divider #(
    parameter int NUM_BITS = 83,
    parameter int DEN_BITS = 48,
    parameter int Q_BITS   = 13,
    parameter int TAG_BITS = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_valid,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    input  wire logic                i_ok,
    input  wire logic [TAG_BITS-1:0] i_tag,
    output logic                     o_valid,
    output logic [Q_BITS-1:0]        o_quot,
    output logic                     o_ok,
    output logic [TAG_BITS-1:0]      o_tag
);
    // Overflow check: quotient >= 2^Q_BITS iff num >> Q_BITS >= den.
    localparam int RB = DEN_BITS + 1;
    logic                r_valid [Q_BITS+1];
    logic [NUM_BITS-1:0] r_num   [Q_BITS+1];
    logic [RB-1:0]       r_rem   [Q_BITS+1];
    logic [DEN_BITS-1:0] r_den   [Q_BITS+1];
    logic                r_ok    [Q_BITS+1];
    logic [TAG_BITS-1:0] r_tag   [Q_BITS+1];
    logic [Q_BITS-1:0]   r_q     [Q_BITS+1];

    logic [NUM_BITS-1:0] n_high;
    assign n_high = i_num >> Q_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= Q_BITS; s++) r_valid[s] <= 1'b0;
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s <= Q_BITS; s++) r_valid[s] <= r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            r_q[0]   <= '0;
            r_rem[0] <= '0;
            r_ok[0]  <= i_ok && (n_high < NUM_BITS'(i_den));
        end
    end

    for (genvar s = 1; s <= Q_BITS; s++) begin : g_stage
        logic [RB-1:0] n_trial;
        logic          n_ge;
        assign n_trial = (s == 1)
            ? {DEN_BITS'(r_num[0] >> Q_BITS), r_num[0][Q_BITS-1]}
            : {r_rem[s-1][RB-2:0], r_num[s-1][Q_BITS-s]};
        assign n_ge = n_trial >= RB'(r_den[s-1]);
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[s] <= r_num[s-1];
                r_den[s] <= r_den[s-1];
                r_tag[s] <= r_tag[s-1];
                r_ok[s]  <= r_ok[s-1];
                r_rem[s] <= n_ge ? n_trial - RB'(r_den[s-1]) : n_trial;
                r_q[s]   <= {r_q[s-1][Q_BITS-2:0], 1'b0} | Q_BITS'(n_ge);
            end
        end
    end

    // First stage seeds remainder with num>>Q_BITS reduced; stage 1 handles bit Q_BITS-1.
    assign o_valid = r_valid[Q_BITS];
    assign o_quot  = r_q[Q_BITS];
    assign o_ok    = r_ok[Q_BITS];
    assign o_tag   = r_tag[Q_BITS];
endmodule
`default_nettype wire

// File: sv/pinhole_point_projector_unit.sv
// Top level of the pinhole point projector: products, sums, division, range check.
//
//  channel | dir | handshake            | payload
//  point   | in  | i_valid / o_stall    | i_point_x/y/z, i_red/green/blue_in
//  pixel   | out | o_valid / i_stall    | o_pixel_column/row, o_blue/green/red_out
//  config  | in  | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One point per cycle while the output is not stalled; the pipeline stages are (multiply, sum, sign
// fix, divider input, DIM_BITS + 1 quotient stages, output register).
// Synchronous active-low reset clears valid bits and loads register defaults.
// Whole pipeline holds while the output register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none
module pinhole_point_projector_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int DIM_BITS    = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [COORD_WIDTH-1:0] i_point_x,
    input  wire logic [COORD_WIDTH-1:0] i_point_y,
    input  wire logic [COORD_WIDTH-1:0] i_point_z,
    input  wire logic [7:0]             i_red_in,
    input  wire logic [7:0]             i_green_in,
    input  wire logic [7:0]             i_blue_in,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [DIM_BITS-1:0]         o_pixel_column,
    output logic [DIM_BITS-1:0]         o_pixel_row,
    output logic [7:0]                  o_blue_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_red_out,
    input  wire logic                   i_cfg_we,
    input  wire logic [ppp_pkg::REG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0] i_cfg_data
);
    localparam int CW   = COORD_WIDTH;
    localparam int PW   = 2 * CW;
    localparam int SW   = PW + 2;          // sum of three products
    localparam int DW   = CW + FRAC_BITS;  // |z| << FRAC_BITS
    localparam int QB   = DIM_BITS + 1;
    localparam int IMW  = DIM_BITS + 1;
    localparam int TAGW = 3 * ppp_pkg::COLOR_BITS;

    // Configuration registers.
    logic signed [CW-1:0] r_kux, r_kuy, r_kuz, r_kvx, r_kvy, r_kvz;
    logic [IMW-1:0] r_width, r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kux <= CW'(30058348);
            r_kuy <= '0;
            r_kuz <= CW'(24065802);
            r_kvx <= '0;
            r_kvy <= CW'(29969351);
            r_kvz <= CW'(16277504);
            r_width  <= IMW'(752);
            r_height <= IMW'(480);
        end else if (i_cfg_we) begin
            unique case (ppp_pkg::t_reg_index'(i_cfg_index))
                ppp_pkg::REG_U_X:    r_kux <= i_cfg_data;
                ppp_pkg::REG_U_Y:    r_kuy <= i_cfg_data;
                ppp_pkg::REG_U_Z:    r_kuz <= i_cfg_data;
                ppp_pkg::REG_V_X:    r_kvx <= i_cfg_data;
                ppp_pkg::REG_V_Y:    r_kvy <= i_cfg_data;
                ppp_pkg::REG_V_Z:    r_kvz <= i_cfg_data;
                ppp_pkg::REG_WIDTH:  r_width  <= i_cfg_data[IMW-1:0];
                ppp_pkg::REG_HEIGHT: r_height <= i_cfg_data[IMW-1:0];
                default: ;
            endcase
        end
    end

    // Advance whenever the output register can take a new item.
    logic n_adv;
    logic r_ovalid;
    assign n_adv   = !(r_ovalid && i_stall);
    assign o_stall = !n_adv;

    // Stage 1: six products.
    logic r1_v;
    logic signed [PW-1:0] r1_ux, r1_uy, r1_uz, r1_vx, r1_vy, r1_vz;
    logic signed [CW-1:0] r1_z;
    logic [TAGW-1:0] r1_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (n_adv) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r1_ux <= PW'(r_kux) * PW'($signed(i_point_x));
            r1_uy <= PW'(r_kuy) * PW'($signed(i_point_y));
            r1_uz <= PW'(r_kuz) * PW'($signed(i_point_z));
            r1_vx <= PW'(r_kvx) * PW'($signed(i_point_x));
            r1_vy <= PW'(r_kvy) * PW'($signed(i_point_y));
            r1_vz <= PW'(r_kvz) * PW'($signed(i_point_z));
            r1_z  <= i_point_z;
            r1_tag <= {i_blue_in, i_green_in, i_red_in};
        end
    end

    // Stage 2: sums.
    logic r2_v;
    logic signed [SW-1:0] r2_nu, r2_nv;
    logic signed [CW-1:0] r2_z;
    logic [TAGW-1:0] r2_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (n_adv) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r2_nu <= SW'(r1_ux) + SW'(r1_uy) + SW'(r1_uz);
            r2_nv <= SW'(r1_vx) + SW'(r1_vy) + SW'(r1_vz);
            r2_z  <= r1_z;
            r2_tag <= r1_tag;
        end
    end

    // Stage 3: magnitudes; a nonzero quotient with opposite signs is negative.
    logic r3_v, r3_oku, r3_okv;
    logic [SW-1:0] r3_mu, r3_mv;
    logic [DW-1:0] r3_den;
    logic [TAGW-1:0] r3_tag;
    logic n_zneg, n_uneg, n_vneg;
    logic [CW-1:0] n_zmag;
    logic [SW-1:0] n_mu, n_mv;
    logic [SW-1:0] n_denw;
    assign n_zneg = r2_z[CW-1];
    assign n_uneg = r2_nu[SW-1];
    assign n_vneg = r2_nv[SW-1];
    assign n_zmag = n_zneg ? CW'(-r2_z) : CW'(r2_z);
    assign n_mu = n_uneg ? SW'(-r2_nu) : SW'(r2_nu);
    assign n_mv = n_vneg ? SW'(-r2_nv) : SW'(r2_nv);
    assign n_denw = SW'({n_zmag, {FRAC_BITS{1'b0}}});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (n_adv) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r3_mu  <= n_mu;
            r3_mv  <= n_mv;
            r3_den <= {n_zmag, {FRAC_BITS{1'b0}}};
            // |q| >= 1 with negative sign is outside; zero depth never passes
            r3_oku <= (r2_z != '0) && !((n_uneg != n_zneg) && (n_mu >= n_denw));
            r3_okv <= (r2_z != '0) && !((n_vneg != n_zneg) && (n_mv >= n_denw));
            r3_tag <= r2_tag;
        end
    end

    // Divider lanes.
    logic d_v, d_oku, d_okv, d_vv, d_vok_unused;
    logic [QB-1:0] d_qu, d_qv;
    logic [TAGW-1:0] d_tag;
    logic d_tagv;
    ppp_divider #(.NUM_BITS(SW), .DEN_BITS(DW), .Q_BITS(QB), .TAG_BITS(TAGW)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(n_adv), .i_valid(r3_v),
        .i_num(r3_mu), .i_den(r3_den), .i_ok(r3_oku), .i_tag(r3_tag),
        .o_valid(d_v), .o_quot(d_qu), .o_ok(d_oku), .o_tag(d_tag)
    );
    ppp_divider #(.NUM_BITS(SW), .DEN_BITS(DW), .Q_BITS(QB), .TAG_BITS(1)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(n_adv), .i_valid(r3_v),
        .i_num(r3_mv), .i_den(r3_den), .i_ok(r3_okv), .i_tag(r3_v),
        .o_valid(d_vv), .o_quot(d_qv), .o_ok(d_okv), .o_tag(d_tagv)
    );
    assign d_vok_unused = d_vv & d_tagv;

    // Clamp image sizes to 2^DIM_BITS and range-check.
    logic [IMW-1:0] n_wlim, n_hlim;
    logic n_hit;
    assign n_wlim = (r_width  > IMW'(1 << DIM_BITS)) ? IMW'(1 << DIM_BITS) : r_width;
    assign n_hlim = (r_height > IMW'(1 << DIM_BITS)) ? IMW'(1 << DIM_BITS) : r_height;
    assign n_hit = d_v && d_oku && d_okv && (d_qu < n_wlim) && (d_qv < n_hlim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (n_adv) r_ovalid <= n_hit;
    end
    logic [DIM_BITS-1:0] r_col, r_row;
    logic [TAGW-1:0] r_otag;
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_col  <= d_qu[DIM_BITS-1:0];
            r_row  <= d_qv[DIM_BITS-1:0];
            r_otag <= d_tag;
        end
    end
    assign o_valid        = r_ovalid;
    assign o_pixel_column = r_col;
    assign o_pixel_row    = r_row;
    assign o_blue_out     = r_otag[3*8-1:2*8];
    assign o_green_out    = r_otag[2*8-1:8];
    assign o_red_out      = r_otag[7:0];

    // Both divider lanes run in lockstep.
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n) d_v == d_vv)
        else $error("divider lanes out of step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_column)))
        else $error("output changed under stall");
    a_inrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_hit |-> (d_qu < n_wlim && d_vok_unused))
        else $error("result outside image");
endmodule
`default_nettype wire
